[hw/rtl/mpr_pkg.sv]
// package: shared types and constants of the mesh packet route filter
`timescale 1ns / 1ps

package mpr_pkg;

  // default table size, one entry per node address
  localparam int unsigned NodesDflt   = 16;
  // header length in bytes; longer packets carry a payload
  localparam int unsigned HeaderBytes = 7;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_OWN_NODE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_RADIO_ON  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOP_LIMIT = 2'd2;

  // configuration reset values
  localparam logic [3:0] OwnNodeRst  = 4'd1;
  localparam logic       RadioOnRst  = 1'b1;
  localparam logic [7:0] HopLimitRst = 8'd14;

  typedef struct packed {
    logic [7:0]  packet_length;
    logic [7:0]  origin_node;
    logic [7:0]  dest_node;
    logic [7:0]  prev_hop;
    logic [7:0]  want_hop;
    logic [7:0]  hop_count;
    logic [15:0] seq_number;
  } pkt_t;

  typedef struct packed {
    logic       accepted;
    logic       deliver;
    logic       forward;
    logic [3:0] out_prev_hop;
    logic [3:0] out_next_hop;
    logic [7:0] out_hop_count;
  } res_t;

  // one routing table entry
  typedef struct packed {
    logic [3:0]  gateway;
    logic [7:0]  hops;
    logic [15:0] seq;
  } route_t;

  // table update request from the filter
  typedef struct packed {
    logic       we;
    logic [7:0] origin;
    logic [7:0] prev;
    route_t     entry;
  } tbl_wr_t;

endpackage

[hw/rtl/mpr_if.sv]
// interfaces: packet header, result and configuration channels
`timescale 1ns / 1ps

interface mpr_pkt_if;
  logic          valid;
  logic          ready;
  mpr_pkg::pkt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mpr_res_if;
  logic          valid;
  logic          ready;
  mpr_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mpr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mpr_pkg::CfgIdxW-1:0]   index;
  logic [mpr_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/mpr_route_table.sv]
// routing table and neighbour bitmap, one entry per node, cleared at reset
`timescale 1ns / 1ps

module mpr_route_table #(
  parameter int unsigned Nodes = mpr_pkg::NodesDflt
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rd_node_i,
  output logic [15:0]      rd_seq_o,
  input  mpr_pkg::tbl_wr_t wr_i
);

  localparam int unsigned IdxW = (Nodes > 1) ? $clog2(Nodes) : 1;

  mpr_pkg::route_t route_q [Nodes];
  logic [Nodes-1:0] nbr_q;

  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;
  logic [IdxW-1:0] nbr_idx;

  assign rd_idx  = rd_node_i[IdxW-1:0];
  assign wr_idx  = wr_i.origin[IdxW-1:0];
  assign nbr_idx = wr_i.prev[IdxW-1:0];

  assign rd_seq_o = route_q[rd_idx].seq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Nodes; i++) begin
        route_q[i] <= '0;
      end
      nbr_q <= '0;
    end else if (wr_i.we) begin
      route_q[wr_idx] <= wr_i.entry;
      nbr_q[nbr_idx]  <= 1'b1;
    end
  end

  a_seq_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.we |=> route_q[$past(wr_idx)].seq == $past(wr_i.entry.seq))
    else $error("route sequence not stored");

  a_gw_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.we |=> (route_q[$past(wr_idx)].gateway == $past(wr_i.entry.gateway)) &&
                (route_q[$past(wr_idx)].hops == $past(wr_i.entry.hops)))
    else $error("route gateway or hops not stored");

  a_nbr_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i.we |=> nbr_q[$past(nbr_idx)])
    else $error("neighbour bit not set");

endmodule

[hw/rtl/mesh_packet_route_filter_unit.sv]
// top level: mesh header filter with routing table update and forward rewrite
//
//   channel  dir  carries                         handshake
//   pkt_i    in   one received header             valid / ready
//   res_o    out  accept, deliver, forward, hdr   valid / ready
//   cfg_i    in   register index and data         valid / ready (always ready)
//
// one header per cycle sustained while res_o is ready; a request is registered
// in the input stage and then in the result stage, which drives res_o.
// the table read, freshness compare and table write happen in the same cycle, so a
// header sees every update made by the header before it.
// reset clears the table and bitmap at once; no clearing pass.
// a stalled res_o holds both stages; pkt_i stays ready while the input stage
// is empty or moving.
`timescale 1ns / 1ps

module mesh_packet_route_filter_unit #(
  parameter int unsigned Nodes = mpr_pkg::NodesDflt
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpr_pkt_if.sink   pkt_i,
  mpr_res_if.source res_o,
  mpr_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [3:0] own_node_q;
  logic       radio_on_q;
  logic [7:0] hop_limit_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_node_q  <= mpr_pkg::OwnNodeRst;
      radio_on_q  <= mpr_pkg::RadioOnRst;
      hop_limit_q <= mpr_pkg::HopLimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mpr_pkg::CFG_OWN_NODE:  own_node_q  <= cfg_i.data[3:0];
        mpr_pkg::CFG_RADIO_ON:  radio_on_q  <= cfg_i.data[0];
        mpr_pkg::CFG_HOP_LIMIT: hop_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // input and result stages
  logic          pkt_vld_q;
  mpr_pkg::pkt_t pkt_q;
  logic          res_vld_q;
  mpr_pkg::res_t res_q;
  mpr_pkg::res_t res_d;
  logic          advance;

  assign advance     = !res_vld_q || res_o.ready;
  assign pkt_i.ready = !pkt_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (pkt_i.ready) begin
        pkt_vld_q <= pkt_i.valid;
      end
      if (advance) begin
        res_vld_q <= pkt_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_i.valid && pkt_i.ready) begin
      pkt_q <= pkt_i.data;
    end
    if (advance && pkt_vld_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  // header checks
  localparam logic [8:0] NodeLim = 9'(Nodes);
  localparam logic [7:0] HdrLen  = 8'(mpr_pkg::HeaderBytes);

  logic [7:0]  own8;
  logic        len_ok;
  logic        has_payload;
  logic        hdr_ok;
  logic        hdr_accept;
  logic        fresh;
  logic        dest_local;
  logic        do_deliver;
  logic        do_forward;
  logic [15:0] stored_seq;
  mpr_pkg::tbl_wr_t tbl_wr;

  assign own8        = {4'b0000, own_node_q};
  assign len_ok      = pkt_q.packet_length >= HdrLen;
  assign has_payload = pkt_q.packet_length > HdrLen;

  assign hdr_ok = (pkt_q.origin_node != own8) &&
                  (pkt_q.origin_node != 8'd0) &&
                  ({1'b0, pkt_q.origin_node} < NodeLim) &&
                  ({1'b0, pkt_q.dest_node} < NodeLim) &&
                  (pkt_q.origin_node != pkt_q.dest_node) &&
                  (pkt_q.prev_hop != 8'd0) &&
                  ({1'b0, pkt_q.prev_hop} < NodeLim) &&
                  ({1'b0, pkt_q.want_hop} < NodeLim) &&
                  (pkt_q.prev_hop != pkt_q.want_hop);

  assign hdr_accept = radio_on_q && len_ok && hdr_ok;

  // freshness against the sequence stored before this update
  assign fresh      = stored_seq <= pkt_q.seq_number;
  assign dest_local = (pkt_q.dest_node == own8) || (pkt_q.dest_node == 8'd0);
  assign do_deliver = hdr_accept && fresh && dest_local && has_payload;
  assign do_forward = hdr_accept && fresh && (pkt_q.dest_node != own8) &&
                      (pkt_q.hop_count < hop_limit_q);

  always_comb begin
    res_d               = '0;
    res_d.accepted      = hdr_accept;
    res_d.deliver       = do_deliver;
    res_d.forward       = do_forward;
    if (do_forward) begin
      res_d.out_prev_hop  = own_node_q;
      // gateway of the origin was just set to the last hop
      res_d.out_next_hop  = pkt_q.prev_hop[3:0];
      res_d.out_hop_count = pkt_q.hop_count + 8'd1;
    end
  end

  always_comb begin
    tbl_wr               = '0;
    tbl_wr.we            = pkt_vld_q && advance && hdr_accept;
    tbl_wr.origin        = pkt_q.origin_node;
    tbl_wr.prev          = pkt_q.prev_hop;
    tbl_wr.entry.gateway = pkt_q.prev_hop[3:0];
    tbl_wr.entry.hops    = pkt_q.hop_count;
    tbl_wr.entry.seq     = pkt_q.seq_number;
  end

  mpr_route_table #(
    .Nodes (Nodes)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_node_i (pkt_q.origin_node),
    .rd_seq_o  (stored_seq),
    .wr_i      (tbl_wr)
  );

  a_flags_need_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && (res_q.deliver || res_q.forward) |-> res_q.accepted)
    else $error("deliver or forward without accepted header");

  a_idle_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_q.forward |->
      (res_q.out_prev_hop == 4'd0) && (res_q.out_next_hop == 4'd0) &&
      (res_q.out_hop_count == 8'd0))
    else $error("rewritten header fields set without forward");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_vld_q && advance |=> res_vld_q)
    else $error("request lost between stages");

  a_write_only_on_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.we |-> res_d.accepted && pkt_vld_q && advance)
    else $error("table written without a moving accepted header");

endmodule
